// ===== design/packet_rx_deframer_xor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet receive deframer
// Implication helpers sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKET_RX_DEFRAMER_XOR_UNIT_ASSERT_SVH
`define PACKET_RX_DEFRAMER_XOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PRDX_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRDX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/prdx_pkg.sv =====
// ----------------------------------------------------------------------------
// prdx_pkg
// Types and constants of the packet receive deframer.
// ----------------------------------------------------------------------------
package prdx_pkg;

	typedef enum logic [2:0] {
		PH_HUNT1  = 3'd0,
		PH_HUNT2  = 3'd1,
		PH_TYPE   = 3'd2,
		PH_LENGTH = 3'd3,
		PH_HCHECK = 3'd4,
		PH_DATA   = 3'd5,
		PH_DCHECK = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_FAIL    = 2'd2,
		KIND_TIMEOUT = 2'd3
	} kind_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] REG_TIMEOUT     = 2'd2;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] packet_type;
		logic [7:0] packet_length;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
	} step_out_t;

endpackage

// ===== design/packet_rx_deframer_xor_unit.sv =====
// ----------------------------------------------------------------------------
// packet_rx_deframer_xor_unit
// Sync hunt, header check and XOR-checked data deframer on a byte stream.
// ----------------------------------------------------------------------------
// Requests pass the input register, the core and the output register.
// Throughput: one request per cycle unless m_tready stalls the output.
// Reset: arst_n clears both stream valid flags, the framing state and the
// config registers (sync bytes 0, timeout 100 ticks).
module packet_rx_deframer_xor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] packet_type, [15:8] packet_length,
	                               // [23:16] payload_byte, [31:24] payload_index
	output logic [1:0]  m_tuser,   // [1:0] kind
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import prdx_pkg::*;

	in_item_t  item_in;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      out_free;
	logic      advance;
	step_out_t res;

	assign item_in.op      = s_tuser;
	assign item_in.rx_byte = s_tdata;
	assign advance         = valid_s1 && out_free;

	prdx_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.item     (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	prdx_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.item      (item_s1),
		.res       (res)
	);

	prdx_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== design/prdx_in_reg.sv =====
// ----------------------------------------------------------------------------
// prdx_in_reg
// Input register stage; holds one request until the core takes it.
// ----------------------------------------------------------------------------
module prdx_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  prdx_pkg::in_item_t item,
	input  logic              advance,
	output logic              valid_s1,
	output prdx_pkg::in_item_t item_s1
);
	import prdx_pkg::*;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== design/prdx_core.sv =====
// ----------------------------------------------------------------------------
// prdx_core
// Config registers, framing state and the per-request step logic.
// ----------------------------------------------------------------------------
module prdx_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               step,
	input  prdx_pkg::in_item_t item,
	output prdx_pkg::step_out_t res
);
	import prdx_pkg::*;

	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic [15:0] timeout_q;

	phase_t      phase_q, phase_d;
	logic [7:0]  held_type_q, held_type_d;
	logic [7:0]  held_length_q, held_length_d;
	logic [7:0]  bytes_seen_q, bytes_seen_d;
	logic [7:0]  check_q, check_d;
	logic [15:0] ticks_q, ticks_d;
	logic [15:0] ticks_inc;
	logic [7:0]  hdr_want;
	logic [7:0]  seen_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= '0;
			sync_second_q <= '0;
			timeout_q     <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data[7:0];
				REG_SYNC_SECOND: sync_second_q <= cfg_data[7:0];
				REG_TIMEOUT:     timeout_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT1;
			held_type_q   <= '0;
			held_length_q <= '0;
			bytes_seen_q  <= '0;
			check_q       <= '0;
			ticks_q       <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			held_type_q   <= held_type_d;
			held_length_q <= held_length_d;
			bytes_seen_q  <= bytes_seen_d;
			check_q       <= check_d;
			ticks_q       <= ticks_d;
		end
	end

	assign ticks_inc = (ticks_q == TICKS_MAX) ? ticks_q : ticks_q + 16'd1;
	assign hdr_want  = sync_first_q ^ sync_second_q ^ held_type_q ^ held_length_q;
	assign seen_inc  = bytes_seen_q + 8'd1;

	always_comb begin
		phase_d           = phase_q;
		held_type_d       = held_type_q;
		held_length_d     = held_length_q;
		bytes_seen_d      = bytes_seen_q;
		check_d           = check_q;
		ticks_d           = ticks_q;
		res.valid         = 1'b0;
		res.kind          = KIND_PAYLOAD;
		res.packet_type   = held_type_q;
		res.packet_length = held_length_q;
		res.payload_byte  = '0;
		res.payload_index = '0;
		if (item.op == OP_TICK) begin
			if (phase_q == PH_DATA || phase_q == PH_DCHECK) begin
				ticks_d = ticks_inc;
				if (ticks_inc > timeout_q) begin
					phase_d   = PH_HUNT1;
					res.valid = 1'b1;
					res.kind  = KIND_TIMEOUT;
				end
			end
		end else begin
			case (phase_q)
				PH_HUNT1: begin
					if (item.rx_byte == sync_first_q) begin
						phase_d = PH_HUNT2;
					end
				end
				PH_HUNT2: begin
					phase_d = (item.rx_byte == sync_second_q) ? PH_TYPE : PH_HUNT1;
				end
				PH_TYPE: begin
					held_type_d = item.rx_byte;
					phase_d     = PH_LENGTH;
				end
				PH_LENGTH: begin
					held_length_d = item.rx_byte;
					phase_d       = PH_HCHECK;
				end
				PH_HCHECK: begin
					if (item.rx_byte != hdr_want) begin
						phase_d = PH_HUNT1;
					end else begin
						bytes_seen_d = '0;
						check_d      = '0;
						ticks_d      = '0;
						if (held_length_q == 8'd0) begin
							phase_d   = PH_HUNT1;
							res.valid = 1'b1;
							res.kind  = KIND_ACCEPT;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					check_d           = check_q ^ item.rx_byte;
					bytes_seen_d      = seen_inc;
					if (seen_inc == held_length_q) begin
						phase_d = PH_DCHECK;
					end
					res.valid         = 1'b1;
					res.kind          = KIND_PAYLOAD;
					res.payload_byte  = item.rx_byte;
					res.payload_index = bytes_seen_q;
				end
				PH_DCHECK: begin
					phase_d   = PH_HUNT1;
					res.valid = 1'b1;
					res.kind  = (item.rx_byte == check_q) ? KIND_ACCEPT : KIND_FAIL;
				end
				default: begin
					phase_d = PH_HUNT1;
				end
			endcase
		end
	end

endmodule

// ===== design/prdx_out_reg.sv =====
// ----------------------------------------------------------------------------
// prdx_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module prdx_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  prdx_pkg::step_out_t res,
	output logic                out_free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic [1:0]          m_tuser
);
	import prdx_pkg::*;

	logic        valid_q;
	logic [31:0] data_q;
	logic [1:0]  user_q;

	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load && res.valid) begin
			data_q <= {res.payload_index, res.payload_byte, res.packet_length,
				res.packet_type};
			user_q <= res.kind;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

// ===== design/prdx_checker.sv =====
// ----------------------------------------------------------------------------
// prdx_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_rx_deframer_xor_unit_assert.svh"

module prdx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import prdx_pkg::*;

	`PRDX_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	`PRDX_ASSERT_SAME(a_verdict_no_payload, m_tvalid && m_tuser != KIND_PAYLOAD,
		m_tdata[23:16] == 8'd0 && m_tdata[31:24] == 8'd0, "verdict carries payload")

	`PRDX_ASSERT_SAME(a_index_in_length, m_tvalid && m_tuser == KIND_PAYLOAD,
		m_tdata[31:24] < m_tdata[15:8], "payload index beyond packet length")

endmodule

bind packet_rx_deframer_xor_unit prdx_checker u_prdx_checker (.*);
